>>> rtl/lzw_variable_width_decoder_assert.svh
// assertion macros for the lzw decoder checker
`ifndef LZW_VARIABLE_WIDTH_DECODER_ASSERT_SVH
`define LZW_VARIABLE_WIDTH_DECODER_ASSERT_SVH
// implication checked on every clock edge outside reset
`define LZW_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lzw check failed");
// next-cycle implication
`define LZW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lzw check failed");
`endif

>>> rtl/lzwd_pkg.sv
// shared constants and types for the lzw decoder
`timescale 1ns / 1ps
package lzwd_pkg;
    localparam int MAX_CODE_BITS_DEF = 12;
    localparam int DRAIN_BURST_DEF   = 64;
    localparam logic [1:0] OP_PUSH  = 2'd0;
    localparam logic [1:0] OP_DRAIN = 2'd1;
    localparam logic [1:0] OP_START = 2'd2;
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_BUSY    = 3'd1;
    localparam logic [2:0] ST_BADHDR  = 3'd2;
    localparam logic [2:0] ST_BADCODE = 3'd3;
    localparam logic [2:0] ST_OVERRUN = 3'd4;
    localparam logic [2:0] ST_DONE    = 3'd5;
    localparam logic [2:0] PH_HEADER  = 3'd0;
    localparam logic [2:0] PH_LITERAL = 3'd1;
    localparam logic [2:0] PH_DATA    = 3'd2;
    localparam logic [2:0] PH_DONE    = 3'd3;
    localparam logic [2:0] PH_BADHDR  = 3'd4;
    localparam logic [2:0] PH_BADCODE = 3'd5;
    localparam logic [2:0] PH_OVERRUN = 3'd6;
    localparam int FIRST_WIDTH = 9;
    // result beat
    typedef struct packed {
        logic [19:0] produced_total;
        logic [2:0]  status;
        logic        last;
        logic        out_valid;
        logic [7:0]  out_byte;
    } t_result;
    function automatic logic [2:0] phase_status(input logic [2:0] ph);
        logic [2:0] s;
        s = ST_OK;
        unique case (ph)
            PH_DONE:    s = ST_DONE;
            PH_BADHDR:  s = ST_BADHDR;
            PH_BADCODE: s = ST_BADCODE;
            PH_OVERRUN: s = ST_OVERRUN;
            default:    s = ST_OK;
        endcase
        return s;
    endfunction
endpackage

>>> rtl/lzwd_dict.sv
// dictionary memory: prefix and suffix per entry, registered read
`timescale 1ns / 1ps
module lzwd_dict #(
    parameter int AW = lzwd_pkg::MAX_CODE_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [AW-1:0] i_wprefix,
    input  logic [7:0]    i_wsuffix,
    input  logic [AW-1:0] i_raddr,
    output logic [AW-1:0] o_rprefix,
    output logic [7:0]    o_rsuffix
);
    logic [AW+7:0] r_mem [0:(1<<AW)-1];
    logic [AW+7:0] r_rd;
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= {i_wprefix, i_wsuffix};
        end
        r_rd <= r_mem[i_raddr];
    end
    assign o_rprefix = r_rd[AW+7:8];
    assign o_rsuffix = r_rd[7:0];
endmodule

>>> rtl/lzwd_stack.sv
// string stack memory, registered read
`timescale 1ns / 1ps
module lzwd_stack #(
    parameter int AW = lzwd_pkg::MAX_CODE_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);
    logic [7:0] r_mem [0:(1<<AW)-1];
    logic [7:0] r_rd;
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rd <= r_mem[i_raddr];
    end
    assign o_rdata = r_rd;
endmodule

>>> rtl/lzw_variable_width_decoder.sv
// lzw decoder top level: byte unpacker, code sequencer, chain walk, drain
`timescale 1ns / 1ps
// result path: any beat but a non-empty drain passes S_OUT before its result is valid; a completed code also
//   passes S_CODE, and a dictionary string S_WALK and S_WAIT per link, then S_TAIL
// flow: one beat in flight, s_axis_tready low until its last result is taken;
//   drain reads each byte in S_DRD, waiting there until the output is free, and sends it from S_DOUT
// reset: i_rst_n synchronous active low, restores stream state; memories keep contents
module lzw_variable_width_decoder #(
    parameter int MAX_CODE_BITS = lzwd_pkg::MAX_CODE_BITS_DEF,
    parameter int DRAIN_BURST   = lzwd_pkg::DRAIN_BURST_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // opcode[1:0], stream_byte[9:2], zero pad
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // out_byte[7:0], status[10:8], produced_total[30:11]
    output logic        m_axis_tlast,
    output logic        m_axis_tuser   // out_valid
);
    localparam int AW  = MAX_CODE_BITS;
    localparam int LW  = AW + 1;
    localparam int BW  = 7;
    localparam logic [LW-1:0] DSIZE = LW'(1) << AW;

    typedef enum logic [2:0] {
        S_IDLE, S_CODE, S_WALK, S_WAIT, S_TAIL, S_OUT, S_DRD, S_DOUT
    } t_state;

    t_state        r_state;
    logic [LW-1:0] r_level;
    logic [23:0]   r_buf;
    logic [4:0]    r_held;
    logic [4:0]    r_width;
    logic [LW-1:0] r_limit, r_next;
    logic [AW-1:0] r_prev, r_cur, r_c;
    logic [7:0]    r_last_char;
    logic [2:0]    r_hdr;
    logic [19:0]   r_expect, r_total;
    logic [2:0]    r_phase;
    logic [LW-1:0] r_sp;
    logic [BW-1:0] r_cnt, r_n;
    logic [2:0]    r_dstat;
    lzwd_pkg::t_result r_res;
    logic          r_ovalid;

    logic [1:0] w_op;
    logic [7:0] w_byte;
    assign w_op   = s_axis_tdata[1:0];
    assign w_byte = s_axis_tdata[9:2];
    assign s_axis_tready = (r_state == S_IDLE) && !r_ovalid;
    logic w_acc;
    assign w_acc = s_axis_tvalid && s_axis_tready;

    // dictionary and stack ports
    logic          w_dwe;
    logic [AW-1:0] w_draddr, w_rprefix;
    logic [7:0]    w_rsuffix;
    logic          w_swe;
    logic [AW-1:0] w_swaddr, w_sraddr;
    logic [7:0]    w_swdata, w_srdata;

    lzwd_dict #(.AW(AW)) u_dict (
        .i_clk(i_clk), .i_we(w_dwe), .i_waddr(r_next[AW-1:0]), .i_wprefix(r_prev),
        .i_wsuffix(w_swdata), .i_raddr(w_draddr),
        .o_rprefix(w_rprefix), .o_rsuffix(w_rsuffix)
    );
    lzwd_stack #(.AW(AW)) u_stack (
        .i_clk(i_clk), .i_we(w_swe), .i_waddr(w_swaddr), .i_wdata(w_swdata),
        .i_raddr(w_sraddr), .o_rdata(w_srdata)
    );

    assign w_draddr = r_c;
    assign w_sraddr = r_level[AW-1:0] - AW'(1);
    // a literal byte, or the repeated first byte of a self-referring code, goes to the stack bottom
    assign w_swaddr = (r_state == S_CODE) ? '0 : r_sp[AW-1:0];

    // extracted code from bit buffer (shift unit)
    logic [4:0]  w_held8;
    logic [23:0] w_buf8;
    logic [4:0]  w_widthg;
    logic [LW-1:0] w_limitg;
    logic [4:0]  w_rem;
    logic [23:0] w_shift;
    logic [AW-1:0] w_code;
    logic        w_have;
    always_comb begin
        w_widthg = r_width;
        w_limitg = r_limit;
        if (r_limit == r_next && r_width != 5'(MAX_CODE_BITS)) begin
            w_widthg = r_width + 5'd1;
            w_limitg = r_limit << 1;
        end
        w_buf8  = {r_buf[15:0], w_byte};
        w_held8 = r_held + 5'd8;
        w_have  = w_held8 >= w_widthg;
        w_rem   = w_held8 - w_widthg;
        w_shift = w_buf8 >> w_rem;
        w_code  = AW'(w_shift & ((24'd1 << w_widthg) - 24'd1));
    end

    // status of the single result of a push, start, unused opcode or empty drain; decode may update it
    logic [2:0] w_status;
    always_comb begin
        w_status = lzwd_pkg::phase_status(r_phase);
        if (w_op == lzwd_pkg::OP_START) begin
            w_status = lzwd_pkg::ST_OK;
        end else if (w_op == lzwd_pkg::OP_PUSH) begin
            if (r_phase == lzwd_pkg::PH_HEADER) begin
                if ((r_hdr == 3'd1 && (w_byte & 8'hF0) != 8'h10) ||
                    (r_hdr >= 3'd3 && (r_expect | {4'd0, w_byte, 8'd0}) == '0)) begin
                    w_status = lzwd_pkg::ST_BADHDR;
                end
            end else if ((r_phase == lzwd_pkg::PH_LITERAL ||
                          r_phase == lzwd_pkg::PH_DATA) && r_level != '0) begin
                w_status = lzwd_pkg::ST_BUSY;
            end
        end
    end

    // walk-side combinational control
    logic w_tail_root;
    assign w_tail_root = r_c < AW'(256);

    always_comb begin
        w_dwe = 1'b0; w_swe = 1'b0; w_swdata = 8'd0;
        unique case (r_state)
            S_TAIL: begin
                w_swe = 1'b1;
                w_swdata = r_c[7:0];
                w_dwe = r_next < DSIZE;
            end
            S_WAIT: begin
                w_swe = 1'b1;
                w_swdata = w_rsuffix;
            end
            S_CODE: begin
                w_swe = (r_phase == lzwd_pkg::PH_LITERAL) ? (r_cur != AW'(257))
                      : (r_cur >= AW'(256) && r_cur != AW'(257) &&
                         LW'(r_cur) == r_next);
                w_swdata = r_last_char;
                if (r_phase == lzwd_pkg::PH_LITERAL) w_swdata = r_cur[7:0];
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_level <= '0; r_buf <= '0; r_held <= '0;
            r_width <= 5'(lzwd_pkg::FIRST_WIDTH); r_limit <= LW'(512);
            r_next <= LW'(258); r_prev <= '0; r_last_char <= '0; r_hdr <= '0;
            r_expect <= '0; r_total <= '0; r_phase <= lzwd_pkg::PH_HEADER;
            r_ovalid <= 1'b0; r_sp <= '0; r_cnt <= '0; r_n <= '0; r_dstat <= '0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        r_res <= '{produced_total: (w_op == lzwd_pkg::OP_START) ? 20'd0
                                                                               : r_total,
                                   status: w_status,
                                   last: 1'b1, out_valid: 1'b0, out_byte: 8'd0};
                        unique case (w_op)
                            lzwd_pkg::OP_START: begin
                                r_level <= '0; r_buf <= '0; r_held <= '0;
                                r_prev <= '0; r_last_char <= '0; r_hdr <= '0;
                                r_expect <= '0; r_total <= '0;
                                r_width <= 5'(lzwd_pkg::FIRST_WIDTH);
                                r_limit <= LW'(512); r_next <= LW'(258);
                                r_phase <= lzwd_pkg::PH_HEADER;
                                r_state <= S_OUT;
                            end
                            lzwd_pkg::OP_DRAIN: begin
                                if (r_level != '0) begin
                                    r_n <= (r_level < LW'(DRAIN_BURST))
                                         ? BW'(r_level) : BW'(DRAIN_BURST);
                                    r_dstat <= (r_level > LW'(DRAIN_BURST))
                                         ? lzwd_pkg::ST_BUSY
                                         : lzwd_pkg::phase_status(r_phase);
                                    r_cnt <= '0;
                                    r_state <= S_DRD;
                                end else begin
                                    r_state <= S_OUT;
                                end
                            end
                            lzwd_pkg::OP_PUSH: begin
                                if (r_phase == lzwd_pkg::PH_HEADER) begin
                                    unique case (r_hdr)
                                        3'd0: r_expect <= {w_byte[3:0], 16'd0};
                                        3'd1: if ((w_byte & 8'hF0) != 8'h10) begin
                                            r_phase <= lzwd_pkg::PH_BADHDR;
                                        end
                                        3'd2: r_expect <= r_expect | 20'(w_byte);
                                        default: begin
                                            if ((r_expect | {4'd0, w_byte, 8'd0}) == '0) begin
                                                r_phase <= lzwd_pkg::PH_BADHDR;
                                            end else begin
                                                r_phase <= lzwd_pkg::PH_LITERAL;
                                                r_width <= 5'(lzwd_pkg::FIRST_WIDTH);
                                                r_limit <= LW'(512);
                                                r_next <= LW'(258);
                                            end
                                            r_expect <= r_expect | {4'd0, w_byte, 8'd0};
                                        end
                                    endcase
                                    if (r_hdr < 3'd4) r_hdr <= r_hdr + 3'd1;
                                    r_state <= S_OUT;
                                end else if (r_phase == lzwd_pkg::PH_LITERAL ||
                                             r_phase == lzwd_pkg::PH_DATA) begin
                                    if (r_level != '0) begin
                                        r_state <= S_OUT;
                                    end else begin
                                        r_width <= w_widthg; r_limit <= w_limitg;
                                        if (w_have) begin
                                            r_held <= w_rem;
                                            r_buf <= w_buf8 & ((24'd1 << w_rem) - 24'd1);
                                            r_cur <= w_code;
                                            r_state <= S_CODE;
                                        end else begin
                                            r_held <= w_held8;
                                            r_buf <= w_buf8;
                                            r_state <= S_OUT;
                                        end
                                    end
                                end else begin
                                    r_state <= S_OUT;
                                end
                            end
                            default: r_state <= S_OUT;
                        endcase
                    end
                end
                S_CODE: begin
                    if (r_phase == lzwd_pkg::PH_LITERAL) begin
                        // literal byte is written to the stack bottom in this state
                        r_state <= S_OUT;
                        if (r_cur != AW'(257)) begin
                            r_prev <= r_cur; r_last_char <= r_cur[7:0];
                            if (r_total + 20'd1 > r_expect) begin
                                r_level <= '0; r_phase <= lzwd_pkg::PH_OVERRUN;
                                r_res.status <= lzwd_pkg::ST_OVERRUN;
                            end else begin
                                r_level <= LW'(1);
                                if (r_total + 20'd1 == r_expect) begin
                                    r_phase <= lzwd_pkg::PH_DONE;
                                    r_res.status <= lzwd_pkg::ST_DONE;
                                end else begin
                                    r_phase <= lzwd_pkg::PH_DATA;
                                end
                            end
                        end else begin
                            r_phase <= lzwd_pkg::PH_DATA;
                        end
                    end else if (r_cur == AW'(256) || r_cur == AW'(257)) begin
                        r_width <= 5'(lzwd_pkg::FIRST_WIDTH); r_limit <= LW'(512);
                        r_next <= LW'(258); r_phase <= lzwd_pkg::PH_LITERAL;
                        r_state <= S_OUT;
                    end else if (LW'(r_cur) > r_next) begin
                        r_phase <= lzwd_pkg::PH_BADCODE;
                        r_res.status <= lzwd_pkg::ST_BADCODE;
                        r_state <= S_OUT;
                    end else begin
                        if (LW'(r_cur) == r_next) begin
                            r_sp <= LW'(1); r_c <= r_prev;
                        end else begin
                            r_sp <= '0; r_c <= r_cur;
                        end
                        r_state <= S_WALK;
                    end
                end
                S_WALK: begin
                    if (w_tail_root) begin
                        r_state <= S_TAIL;
                    end else if (r_sp >= DSIZE - LW'(1)) begin
                        r_phase <= lzwd_pkg::PH_BADCODE;
                        r_res.status <= lzwd_pkg::ST_BADCODE;
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    r_sp <= r_sp + LW'(1);
                    r_c <= w_rprefix;
                    r_state <= S_WALK;
                end
                S_TAIL: begin
                    begin : tail_blk
                        logic [LW-1:0] sp2;
                        logic [19:0]   dec;
                        sp2 = r_sp + LW'(1);
                        dec = r_total + 20'(sp2);
                        r_last_char <= r_c[7:0];
                        if (r_next < DSIZE) r_next <= r_next + LW'(1);
                        r_prev <= r_cur;
                        if (dec > r_expect) begin
                            r_level <= '0; r_phase <= lzwd_pkg::PH_OVERRUN;
                            r_res.status <= lzwd_pkg::ST_OVERRUN;
                        end else begin
                            r_level <= sp2;
                            if (dec == r_expect) begin
                                r_phase <= lzwd_pkg::PH_DONE;
                                r_res.status <= lzwd_pkg::ST_DONE;
                            end
                        end
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_ovalid) begin
                        r_ovalid <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                S_DRD: begin
                    if (!r_ovalid || (m_axis_tvalid && m_axis_tready)) r_state <= S_DOUT;
                end
                S_DOUT: begin
                    r_res <= '{produced_total: r_total + 20'd1, status: r_dstat,
                               last: (r_cnt + BW'(1)) == r_n, out_valid: 1'b1,
                               out_byte: w_srdata};
                    r_total <= r_total + 20'd1;
                    r_level <= r_level - LW'(1);
                    r_cnt <= r_cnt + BW'(1);
                    r_ovalid <= 1'b1;
                    r_state <= ((r_cnt + BW'(1)) == r_n) ? S_IDLE : S_DRD;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {1'b0, r_res.produced_total, r_res.status, r_res.out_byte};
    assign m_axis_tlast  = r_res.last;
    assign m_axis_tuser  = r_res.out_valid;
endmodule

>>> rtl/lzwd_checker.sv
// port-level checker for the lzw decoder, bound to the top level
`timescale 1ns / 1ps
`include "lzw_variable_width_decoder_assert.svh"
module lzwd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic        m_axis_tlast,
    input logic        m_axis_tuser
);
    `LZW_ASSERT_IMPL(a_no_accept_while_out, i_clk, i_rst_n, m_axis_tvalid, !s_axis_tready)
    `LZW_ASSERT_IMPL(a_empty_is_last, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tuser, m_axis_tlast)
    `LZW_ASSERT_IMPL(a_empty_zero, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tuser, m_axis_tdata[7:0] == 8'd0)
    `LZW_ASSERT_NEXT(a_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
endmodule
bind lzw_variable_width_decoder lzwd_checker u_lzwd_checker (.*);

>>> sim/tb.sv
// self-checking testbench for the lzw variable width decoder
`timescale 1ns / 1ps
module tb;
    import lzwd_pkg::*;

    localparam logic [1:0] OP_NONE = 2'd3;   // unused opcode, block answers with status
    localparam int DICT_N  = 4096;
    localparam int CLEAR   = 'h100;
    localparam int RESTART = 'h101;
    localparam int FREE0   = 'h102;
    // kinds of generated streams
    localparam int SK_GOOD    = 0;
    localparam int SK_TRUNC   = 1;
    localparam int SK_BADCODE = 2;
    localparam int SK_OVERRUN = 3;
    localparam int SK_LONG    = 4;

    typedef struct {
        logic [1:0] op;
        logic [7:0] sbyte;
    } t_item;

    typedef struct {
        logic [1:0] op;
        logic [7:0] sbyte;
        bit         typed;
        t_result    res;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        m_axis_tuser;

    lzw_variable_width_decoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #4 i_clk = ~i_clk;

    // ---------------- decoder mirror ----------------
    logic [11:0] dict_prefix [DICT_N];
    logic [7:0]  dict_suffix [DICT_N];
    logic [7:0]  out_stack   [DICT_N];
    int          stack_cnt, bit_acc, bit_cnt, code_w, w_limit, nxt_entry, prior_code;
    int          hdr_cnt, target_len, delivered;
    logic [7:0]  tail_char;
    logic [2:0]  phase;

    t_item   item_q[$];
    t_result pending_q[$];   // expected beats, oldest first
    bit      keep_pred;
    int      fails, beats_seen, streams_made;

    function automatic logic [2:0] phase_code();
        case (phase)
            PH_DONE:    return ST_DONE;
            PH_BADHDR:  return ST_BADHDR;
            PH_BADCODE: return ST_BADCODE;
            PH_OVERRUN: return ST_OVERRUN;
            default:    return ST_OK;
        endcase
    endfunction

    task automatic put_beat(input logic [7:0] b, input bit v, input bit l, input logic [2:0] s);
        t_result r;
        r.out_byte = b;
        r.out_valid = v;
        r.last = l;
        r.status = s;
        r.produced_total = delivered[19:0];
        if (keep_pred) pending_q.insert(pending_q.size(), r);
    endtask

    function automatic void dict_restart();
        code_w = FIRST_WIDTH;
        w_limit = 1 << FIRST_WIDTH;
        nxt_entry = FREE0;
        phase = PH_LITERAL;
    endfunction

    task automatic stream_restart();
        stack_cnt = 0; bit_acc = 0; bit_cnt = 0; prior_code = 0; tail_char = 0;
        hdr_cnt = 0; target_len = 0; delivered = 0;
        dict_restart();
        phase = PH_HEADER;
    endtask

    function automatic void length_check();
        if (delivered + stack_cnt > target_len) begin
            stack_cnt = 0;
            phase = PH_OVERRUN;
        end else if (delivered + stack_cnt == target_len) begin
            phase = PH_DONE;
        end
    endfunction

    function automatic void decode_code(input int code);
        int c, sp;
        c = code;
        sp = 0;
        if (phase == PH_LITERAL) begin
            phase = PH_DATA;
            if (c != RESTART) begin
                prior_code = c;
                tail_char = c[7:0];
                out_stack[0] = tail_char;
                stack_cnt = 1;
                length_check();
            end
            return;
        end
        if (c == CLEAR || c == RESTART) begin
            dict_restart();
            return;
        end
        if (c >= nxt_entry) begin
            if (c != nxt_entry) begin
                phase = PH_BADCODE;
                return;
            end
            out_stack[sp] = tail_char;
            sp++;
            c = prior_code;
        end
        while (c >= 256) begin
            if (sp >= DICT_N - 1) begin
                phase = PH_BADCODE;
                return;
            end
            out_stack[sp] = dict_suffix[c % DICT_N];
            sp++;
            c = dict_prefix[c % DICT_N];
        end
        tail_char = c[7:0];
        out_stack[sp] = tail_char;
        sp++;
        if (nxt_entry < DICT_N) begin
            dict_suffix[nxt_entry] = tail_char;
            dict_prefix[nxt_entry] = prior_code[11:0];
            nxt_entry++;
        end
        prior_code = code % DICT_N;
        stack_cnt = sp;
        length_check();
    endfunction

    function automatic logic [2:0] push_compressed(input logic [7:0] b);
        int c;
        if (phase == PH_HEADER) begin
            case (hdr_cnt)
                0: target_len = int'(b[3:0]) << 16;
                1: if (b[7:4] != 4'h1) phase = PH_BADHDR;
                2: target_len |= int'(b);
                default: begin
                    target_len |= int'(b) << 8;
                    if (target_len == 0) phase = PH_BADHDR;
                    else dict_restart();
                end
            endcase
            if (hdr_cnt < 4) hdr_cnt++;
            return phase_code();
        end
        if (phase != PH_LITERAL && phase != PH_DATA) return phase_code();
        if (stack_cnt > 0) return ST_BUSY;
        if (w_limit == nxt_entry && code_w != MAX_CODE_BITS_DEF) begin
            code_w++;
            w_limit <<= 1;
        end
        bit_acc = ((bit_acc << 8) | int'(b)) & 'hFFFFFF;
        bit_cnt += 8;
        if (bit_cnt >= code_w) begin
            c = (bit_acc >> (bit_cnt - code_w)) & ((1 << code_w) - 1);
            bit_cnt -= code_w;
            bit_acc &= (1 << bit_cnt) - 1;
            decode_code(c);
        end
        return phase_code();
    endfunction

    // advance the mirror by one input item and queue the beats it causes
    task automatic predict_item(input logic [1:0] op, input logic [7:0] b);
        int n;
        logic [2:0] s;
        if (op == OP_PUSH) begin
            s = push_compressed(b);
            put_beat(8'h00, 1'b0, 1'b1, s);
        end else if (op == OP_START) begin
            stream_restart();
            put_beat(8'h00, 1'b0, 1'b1, ST_OK);
        end else if (op == OP_DRAIN && stack_cnt > 0) begin
            n = (stack_cnt < DRAIN_BURST_DEF) ? stack_cnt : DRAIN_BURST_DEF;
            s = (stack_cnt - n > 0) ? ST_BUSY : phase_code();
            for (int k = 0; k < n; k++) begin
                stack_cnt--;
                delivered++;
                put_beat(out_stack[stack_cnt], 1'b1, k == n - 1, s);
            end
        end else begin
            put_beat(8'h00, 1'b0, 1'b1, phase_code());
        end
    endtask

    task automatic add_item(input logic [1:0] op, input logic [7:0] b);
        t_item it;
        it.op = op;
        it.sbyte = b;
        item_q.insert(item_q.size(), it);
        predict_item(op, b);
    endtask

    // ---------------- stream generator ----------------
    int enc_len [DICT_N];   // decoded length of each dictionary entry
    int pk_acc, pk_cnt;

    task automatic push_and_drain(input logic [7:0] b);
        add_item(OP_PUSH, b);
        while (stack_cnt > 0) begin
            if ($urandom_range(0, 9) == 0) add_item(OP_PUSH, 8'($urandom));  // ignored while busy
            add_item(OP_DRAIN, 8'($urandom));
        end
    endtask

    task automatic pack_code(input int code, input int w);
        pk_acc = (pk_acc << w) | code;
        pk_cnt += w;
        while (pk_cnt >= 8) begin
            pk_cnt -= 8;
            push_and_drain(8'(pk_acc >> pk_cnt));
            pk_acc &= (1 << pk_cnt) - 1;
        end
    endtask

    task automatic make_stream(input int kind);
        int tlen, hlen, left, max_codes, bad_at, n, ne, lim, w, prv, code, sel, j;
        bit lit;
        tlen = (kind == SK_LONG) ? 4000 : $urandom_range(2, 120);
        hlen = (kind == SK_OVERRUN) ? tlen - 1 : tlen;
        max_codes = (kind == SK_LONG) ? 60 : (kind == SK_TRUNC) ? $urandom_range(1, 5) : 100000;
        bad_at = $urandom_range(1, 4);
        streams_made++;
        add_item(OP_START, 8'($urandom));
        add_item(OP_PUSH, {4'($urandom), 4'(hlen >> 16)});
        add_item(OP_PUSH, {4'h1, 4'($urandom)});
        add_item(OP_PUSH, 8'(hlen));
        add_item(OP_PUSH, 8'(hlen >> 8));
        for (int i = 0; i < 256; i++) enc_len[i] = 1;
        pk_acc = 0; pk_cnt = 0;
        ne = FREE0; lim = 512; w = 9; prv = 0; lit = 1'b1;
        left = tlen;
        n = 0;
        while (left > 0 && n < max_codes) begin
            if (lim == ne && w < MAX_CODE_BITS_DEF) begin
                w++;
                lim <<= 1;
            end
            if (kind == SK_BADCODE && n >= bad_at && !lit && ne + 1 < (1 << w)) begin
                // code beyond the next free entry
                pack_code($urandom_range(ne + 1, (1 << w) - 1), w);
                break;
            end
            sel = $urandom_range(0, 99);
            if (lit) begin
                // a restart right at stream start leaves the previous code at zero
                code = (n == 0 && sel < 10) ? RESTART : $urandom_range(0, 255);
                lit = 1'b0;
                if (code != RESTART) begin
                    prv = code;
                    left--;
                end
            end else if (sel < 4 && kind != SK_LONG) begin
                code = (sel < 2) ? CLEAR : RESTART;
                ne = FREE0; lim = 512; lit = 1'b1;
            end else begin
                code = $urandom_range(0, 255);
                if (sel < 35 && enc_len[prv] + 1 <= left) begin
                    code = ne;   // string that refers to itself
                end else if (sel < 70 && ne > FREE0) begin
                    j = $urandom_range(FREE0, ne - 1);
                    if (enc_len[j] <= left) code = j;
                end
                if (ne < DICT_N) begin
                    enc_len[ne] = enc_len[prv] + 1;
                    ne++;
                end
                left -= enc_len[code];
                prv = code;
            end
            // a clear or restart code still goes out at the width in use before it
            pack_code(code, w);
            if (code == CLEAR || code == RESTART) w = 9;
            n++;
        end
        if (kind != SK_TRUNC && pk_cnt > 0) push_and_drain(8'(pk_acc << (8 - pk_cnt)));
        push_and_drain(8'($urandom));   // after the end, status sticks
    endtask

    // ---------------- directed part ----------------
    function automatic t_result quiet_beat(input logic [2:0] s);
        t_result r;
        r = '0;
        r.last = 1'b1;
        r.status = s;
        return r;
    endfunction

    task automatic build_directed();
        t_row rows[$];
        rows = '{
            '{OP_DRAIN, 8'h00, 1, quiet_beat(ST_OK)},      // drain right after reset
            '{OP_NONE,  8'hFF, 1, quiet_beat(ST_OK)},      // unused opcode
            '{OP_PUSH,  8'h0F, 1, quiet_beat(ST_OK)},
            '{OP_PUSH,  8'hFF, 1, quiet_beat(ST_BADHDR)},  // nibble check fails
            '{OP_PUSH,  8'h00, 1, quiet_beat(ST_BADHDR)},  // error sticks
            '{OP_DRAIN, 8'h00, 1, quiet_beat(ST_BADHDR)},
            '{OP_START, 8'h00, 1, quiet_beat(ST_OK)},
            '{OP_PUSH,  8'h00, 1, quiet_beat(ST_OK)},
            '{OP_PUSH,  8'h1A, 1, quiet_beat(ST_OK)},
            '{OP_PUSH,  8'h00, 1, quiet_beat(ST_OK)},
            '{OP_PUSH,  8'h00, 1, quiet_beat(ST_BADHDR)},  // zero length
            '{OP_START, 8'h00, 1, quiet_beat(ST_OK)},
            '{OP_PUSH,  8'hF0, 0, '0},                     // length 3
            '{OP_PUSH,  8'h10, 0, '0},
            '{OP_PUSH,  8'h03, 0, '0},
            '{OP_PUSH,  8'h00, 0, '0},
            '{OP_PUSH,  8'h20, 0, '0},                     // literal 'A'
            '{OP_PUSH,  8'hC0, 0, '0},
            '{OP_DRAIN, 8'h00, 0, '0},
            '{OP_PUSH,  8'h80, 0, '0},                     // code equal to next free
            '{OP_PUSH,  8'h55, 0, '0},                     // ignored, still busy
            '{OP_DRAIN, 8'h00, 0, '0},
            '{OP_PUSH,  8'h55, 0, '0}                      // finished
        };
        foreach (rows[i]) begin
            keep_pred = !rows[i].typed;
            add_item(rows[i].op, rows[i].sbyte);
            if (rows[i].typed) pending_q.insert(pending_q.size(), rows[i].res);
        end
        keep_pred = 1'b1;
    endtask

    // ---------------- idling and handshakes ----------------
    int items_taken, hold_cnt;
    bit hold_done;
    int idle_mode;   // 0 receiver idles more, 1 sender idles more, 2 no idling

    always @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) items_taken <= items_taken + 1;
    end

    always @(posedge i_clk) begin
        if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            m_axis_tready <= 1'b0;
        end else if (!hold_done && items_taken >= 120) begin
            hold_cnt <= 600;   // long receiver hold-off, the block must back up
            hold_done <= 1'b1;
            m_axis_tready <= 1'b0;
        end else begin
            case (idle_mode)
                0: m_axis_tready <= ($urandom_range(0, 99) >= 65);
                1: m_axis_tready <= ($urandom_range(0, 99) >= 38);
                default: m_axis_tready <= 1'b1;
            endcase
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            beats_seen++;
            if (pending_q.size() == 0) begin
                $error("unexpected beat tdata=%0h", m_axis_tdata);
                fails++;
            end else begin
                want = pending_q.pop_front();
                if (m_axis_tdata[7:0] !== want.out_byte) begin
                    $error("out_byte exp %0h got %0h", want.out_byte, m_axis_tdata[7:0]);
                    fails++;
                end
                if (m_axis_tuser !== want.out_valid) begin
                    $error("out_valid exp %0h got %0h", want.out_valid, m_axis_tuser);
                    fails++;
                end
                if (m_axis_tlast !== want.last) begin
                    $error("last exp %0h got %0h", want.last, m_axis_tlast);
                    fails++;
                end
                if (m_axis_tdata[10:8] !== want.status) begin
                    $error("status exp %0h got %0h", want.status, m_axis_tdata[10:8]);
                    fails++;
                end
                if (m_axis_tdata[30:11] !== want.produced_total) begin
                    $error("produced_total exp %0h got %0h", want.produced_total,
                           m_axis_tdata[30:11]);
                    fails++;
                end
            end
        end
    end

    initial begin
        #20ms;
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        int sent, wait_cnt;
        items_taken = 0; hold_cnt = 0; hold_done = 0; idle_mode = 0;
        fails = 0; beats_seen = 0; streams_made = 0;
        for (int i = 0; i < DICT_N; i++) begin
            dict_prefix[i] = '0;
            dict_suffix[i] = '0;
            out_stack[i] = '0;
        end
        keep_pred = 1'b1;
        stream_restart();
        build_directed();
        make_stream(SK_LONG);
        while (item_q.size() < 280) begin
            case ($urandom_range(0, 9))
                0: make_stream(SK_TRUNC);
                1: make_stream(SK_BADCODE);
                2: make_stream(SK_OVERRUN);
                3: begin
                    // noise: unused opcode, a drain, a start and two random header bytes
                    add_item(OP_NONE, 8'($urandom));
                    add_item(OP_DRAIN, 8'($urandom));
                    add_item(OP_START, 8'($urandom));
                    add_item(OP_PUSH, 8'($urandom));
                    add_item(OP_PUSH, 8'($urandom));
                end
                default: make_stream(SK_GOOD);
            endcase
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        sent = 0;
        foreach (item_q[i]) begin
            idle_mode = (sent < item_q.size() / 3) ? 0 : (sent < 2 * item_q.size() / 3) ? 1 : 2;
            while ((idle_mode == 0 && $urandom_range(0, 99) < 38) ||
                   (idle_mode == 1 && $urandom_range(0, 99) < 65)) begin
                s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata <= {6'b0, item_q[i].sbyte, item_q[i].op};
            @(posedge i_clk);
            while (!s_axis_tready) @(posedge i_clk);
            sent++;
        end
        s_axis_tvalid <= 1'b0;

        wait_cnt = 0;
        while (pending_q.size() > 0 && wait_cnt < 200000) begin
            @(posedge i_clk);
            wait_cnt++;
        end
        repeat (300) @(posedge i_clk);
        $display("covered %0d items in %0d generated streams, %0d result beats checked",
                 sent, streams_made, beats_seen);
        $display("headers, literals, restarts, self-referring codes, bad codes, overruns");
        if (fails == 0 && pending_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
